[rtl/core/ufmc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the union-find maze carver
// no dependencies

package ufmc_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int COORD_W    = 5;
  localparam int SIZE_W     = 6;

  typedef enum logic [1:0] {
    ACT_CARVE = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_REMOVED   = 2'd0,
    ST_CONNECTED = 2'd1,
    ST_OFF_GRID  = 2'd2,
    ST_DONE      = 2'd3
  } status_t;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [1:0]         direction;
  } ufmc_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       open_way;
  } ufmc_out_t;

  // operands of the shared index unit
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SIZE_W-1:0]  rows;
  } ufmc_idx_req_t;

endpackage

[rtl/core/ufmc_ram.sv]
`timescale 1ns / 1ps
// simple dual-port ram, one write and one registered read per cycle
// no dependencies

module ufmc_ram #(
  parameter int DATA_W = 1,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ufmc_index_unit.sv]
`timescale 1ns / 1ps
// cell index unit: col * rows + row, shared by both index computations
// depends on ufmc_pkg

module ufmc_index_unit import ufmc_pkg::*; (
  input  ufmc_idx_req_t     req,
  output logic [CELL_W-1:0] idx
);

  logic [COORD_W+SIZE_W-1:0] prod;
  logic [COORD_W+SIZE_W:0]   sum;

  assign prod = (COORD_W+SIZE_W)'(req.col) * (COORD_W+SIZE_W)'(req.rows);
  assign sum  = {1'b0, prod} + (COORD_W+SIZE_W+1)'(req.row);
  // bounded by the clamped grid size, fits the cell index
  assign idx  = sum[CELL_W-1:0];

endmodule

[rtl/core/union_find_maze_carver_core.sv]
`timescale 1ns / 1ps
// Query: decode, neighbour index, wall read and wall check, then result; clear: one entry per cycle.
// Carve: decode, neighbour index, two root walks, then the link; each parent step of a
// walk is one read of the parent ram and one compare.
// One request at a time; the next is taken as soon as the result is registered.
// Reset (synchronous, rst_n low) restores the grid size to 32 x 32 and starts a
// clearing pass over every entry of the rams, during which no request is taken.

module union_find_maze_carver_core import ufmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ufmc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ufmc_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_OTHER,
    S_WRD,
    S_WCHK,
    S_FRD,
    S_FCHK,
    S_LINK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  width_r, width_nxt, height_r, height_nxt;
  ufmc_in_t           req_r, req_nxt;
  logic [CELL_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               clr_reply_r, clr_reply_nxt;
  logic [COORD_W-1:0] nbr_col_r, nbr_col_nxt, nbr_row_r, nbr_row_nxt;
  logic               is_right_r, is_right_nxt;
  logic               wall_other_r, wall_other_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt, other_r, other_nxt;
  logic [CELL_W-1:0]  wall_idx_r, wall_idx_nxt;
  logic [CELL_W-1:0]  cur_r, cur_nxt, root_a_r, root_a_nxt, root_b_r, root_b_nxt;
  logic               find_b_r, find_b_nxt;
  ufmc_out_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  ufmc_out_t          out_r, out_nxt;

  logic [SIZE_W-1:0]  w_eff, h_eff;
  logic               cell_off, on_grid;
  logic [COORD_W-1:0] dec_col, dec_row;
  logic               dec_right, dec_other;

  ufmc_idx_req_t      idx_req;
  logic [CELL_W-1:0]  idx;

  logic               par_we, right_we, down_we;
  logic [CELL_W-1:0]  par_waddr, par_wdata, wall_waddr;
  logic               wall_wdata;
  logic [CELL_W-1:0]  par_rdata;
  logic               right_rdata, down_rdata;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

  assign w_eff = clamp_size(width_r, SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(height_r, SIZE_W'(MAX_HEIGHT));

  // bounds and neighbour of the registered request
  always_comb begin
    cell_off  = ({1'b0, req_r.cell_x} >= w_eff) || ({1'b0, req_r.cell_y} >= h_eff);
    dec_col   = req_r.cell_x;
    dec_row   = req_r.cell_y;
    dec_right = 1'b1;
    dec_other = 1'b0;
    unique case (dir_t'(req_r.direction))
      DIR_RIGHT: begin
        on_grid = ({1'b0, req_r.cell_x} + SIZE_W'(1)) < w_eff;
        dec_col = req_r.cell_x + COORD_W'(1);
      end
      DIR_DOWN: begin
        on_grid   = ({1'b0, req_r.cell_y} + SIZE_W'(1)) < h_eff;
        dec_row   = req_r.cell_y + COORD_W'(1);
        dec_right = 1'b0;
      end
      DIR_LEFT: begin
        on_grid   = req_r.cell_x != '0;
        dec_col   = req_r.cell_x - COORD_W'(1);
        dec_other = 1'b1;
      end
      DIR_UP: begin
        on_grid   = req_r.cell_y != '0;
        dec_row   = req_r.cell_y - COORD_W'(1);
        dec_right = 1'b0;
        dec_other = 1'b1;
      end
      default: begin
        on_grid = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_req.rows = h_eff;
    if (state_r == S_OTHER) begin
      idx_req.col = nbr_col_r;
      idx_req.row = nbr_row_r;
    end else begin
      idx_req.col = req_r.cell_x;
      idx_req.row = req_r.cell_y;
    end
  end

  ufmc_index_unit u_index (
    .req (idx_req),
    .idx (idx)
  );

  // ram write ports: clearing sweep or the link of a carve
  always_comb begin
    if (state_r == S_CLEAR) begin
      par_we     = 1'b1;
      par_waddr  = clr_cnt_r;
      par_wdata  = clr_cnt_r;
      right_we   = 1'b1;
      down_we    = 1'b1;
      wall_waddr = clr_cnt_r;
      wall_wdata = 1'b1;
    end else begin
      par_we     = (state_r == S_LINK) && (root_a_r != root_b_r);
      par_waddr  = root_b_r;
      par_wdata  = root_a_r;
      right_we   = par_we && is_right_r;
      down_we    = par_we && !is_right_r;
      wall_waddr = wall_idx_r;
      wall_wdata = 1'b0;
    end
  end

  ufmc_ram #(.DATA_W(CELL_W), .ADDR_W(CELL_W)) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (cur_r),
    .rdata (par_rdata)
  );

  ufmc_ram #(.DATA_W(1), .ADDR_W(CELL_W)) u_right (
    .clk   (clk),
    .we    (right_we),
    .waddr (wall_waddr),
    .wdata (wall_wdata),
    .raddr (wall_idx_r),
    .rdata (right_rdata)
  );

  ufmc_ram #(.DATA_W(1), .ADDR_W(CELL_W)) u_down (
    .clk   (clk),
    .we    (down_we),
    .waddr (wall_waddr),
    .wdata (wall_wdata),
    .raddr (wall_idx_r),
    .rdata (down_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    req_nxt        = req_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_reply_nxt  = clr_reply_r;
    nbr_col_nxt    = nbr_col_r;
    nbr_row_nxt    = nbr_row_r;
    is_right_nxt   = is_right_r;
    wall_other_nxt = wall_other_r;
    cell_nxt       = cell_r;
    other_nxt      = other_r;
    wall_idx_nxt   = wall_idx_r;
    cur_nxt        = cur_r;
    root_a_nxt     = root_a_r;
    root_b_nxt     = root_b_r;
    find_b_nxt     = find_b_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  width_nxt  = cfg_wdata;
        CFG_GRID_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == CELL_W'(CELL_COUNT - 1)) begin
          if (clr_reply_r) begin
            res_nxt.status   = ST_DONE;
            res_nxt.open_way = 1'b0;
            state_nxt        = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        nbr_col_nxt      = dec_col;
        nbr_row_nxt      = dec_row;
        is_right_nxt     = dec_right;
        wall_other_nxt   = dec_other;
        cell_nxt         = idx;
        res_nxt.open_way = 1'b0;
        state_nxt        = S_RESP;
        priority if (req_r.action == ACT_CLEAR) begin
          clr_cnt_nxt   = '0;
          clr_reply_nxt = 1'b1;
          state_nxt     = S_CLEAR;
        end else if (req_r.action != ACT_CARVE && req_r.action != ACT_QUERY) begin
          res_nxt.status = ST_DONE;
        end else if (cell_off) begin
          res_nxt.status = ST_OFF_GRID;
        end else if (!on_grid) begin
          res_nxt.status = (req_r.action == ACT_QUERY) ? ST_DONE : ST_OFF_GRID;
        end else begin
          state_nxt = S_OTHER;
        end
      end
      S_OTHER: begin
        other_nxt    = idx;
        wall_idx_nxt = wall_other_r ? idx : cell_r;
        cur_nxt      = cell_r;
        find_b_nxt   = 1'b0;
        state_nxt    = (req_r.action == ACT_QUERY) ? S_WRD : S_FRD;
      end
      S_WRD: begin
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        res_nxt.status   = ST_DONE;
        res_nxt.open_way = is_right_r ? !right_rdata : !down_rdata;
        state_nxt        = S_RESP;
      end
      S_FRD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        // a root points at itself
        if (par_rdata == cur_r) begin
          if (!find_b_r) begin
            root_a_nxt = cur_r;
            cur_nxt    = other_r;
            find_b_nxt = 1'b1;
            state_nxt  = S_FRD;
          end else begin
            root_b_nxt = cur_r;
            state_nxt  = S_LINK;
          end
        end else begin
          cur_nxt   = par_rdata;
          state_nxt = S_FRD;
        end
      end
      S_LINK: begin
        res_nxt.status   = (root_a_r != root_b_r) ? ST_REMOVED : ST_CONNECTED;
        res_nxt.open_way = 1'b0;
        state_nxt        = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          clr_reply_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      width_r     <= SIZE_W'(MAX_WIDTH);
      height_r    <= SIZE_W'(MAX_HEIGHT);
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      find_b_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      find_b_r    <= find_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    nbr_col_r    <= nbr_col_nxt;
    nbr_row_r    <= nbr_row_nxt;
    is_right_r   <= is_right_nxt;
    wall_other_r <= wall_other_nxt;
    cell_r       <= cell_nxt;
    other_r      <= other_nxt;
    wall_idx_r   <= wall_idx_nxt;
    cur_r        <= cur_nxt;
    root_a_r     <= root_a_nxt;
    root_b_r     <= root_b_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/ufmc_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the maze carver core, bound to the top level
// depends on ufmc_pkg and union_find_maze_carver_core

module ufmc_checker import ufmc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input ufmc_out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // open travel is only reported by a completed query
  a_open_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.open_way |-> out_data.status == ST_DONE)
    else $error("open_way set with wrong status");

  // the clearing pass after reset holds off requests
  a_reset_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("request taken during reset clearing pass");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind union_find_maze_carver_core ufmc_checker u_ufmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for union_find_maze_carver_core: walls and set table
// are tracked in the bench and every result is checked; needs ufmc_pkg and the core

module testbench;
  import ufmc_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int RUN_LIMIT = 30_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ufmc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ufmc_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  union_find_maze_carver_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // maze as the bench sees it
  bit wall_east [CELL_COUNT];
  bit wall_south [CELL_COUNT];
  bit [CELL_W-1:0] set_link [CELL_COUNT];
  logic [SIZE_W-1:0] size_cols = 6'd32;
  logic [SIZE_W-1:0] size_rows = 6'd32;

  ufmc_in_t pending_requests[$];
  ufmc_out_t expected_replies[$];
  int unsigned idle_pct = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned usable(logic [SIZE_W-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void wipe_maze();
    for (int i = 0; i < CELL_COUNT; i++) begin
      wall_east[i] = 1'b1;
      wall_south[i] = 1'b1;
      set_link[i] = CELL_W'(i);
    end
  endfunction

  function automatic int unsigned root_of(int unsigned c);
    int unsigned p;
    for (int s = 0; s < CELL_COUNT; s++) begin
      p = set_link[c];
      if (p == c) break;
      c = p;
    end
    return c;
  endfunction

  // applies one request to the tracked maze and returns the result it owes
  function automatic ufmc_out_t carve_step(ufmc_in_t req);
    ufmc_out_t res;
    int unsigned w, h, x, y, home, nbr, wall, ra, rb;
    bit on_grid, is_right;
    w = usable(size_cols, MAX_WIDTH);
    h = usable(size_rows, MAX_HEIGHT);
    x = req.cell_x;
    y = req.cell_y;
    res.status = ST_DONE;
    res.open_way = 1'b0;
    if (req.action == ACT_CLEAR) begin
      wipe_maze();
    end else if (req.action == ACT_CARVE || req.action == ACT_QUERY) begin
      if (x >= w || y >= h) begin
        res.status = ST_OFF_GRID;
      end else begin
        home = x * h + y;
        nbr = home;
        wall = home;
        is_right = 1'b1;
        case (req.direction)
          DIR_RIGHT: begin
            on_grid = (x + 1 < w);
            if (on_grid) nbr = (x + 1) * h + y;
          end
          DIR_DOWN: begin
            on_grid = (y + 1 < h);
            if (on_grid) nbr = home + 1;
            is_right = 1'b0;
          end
          DIR_LEFT: begin
            on_grid = (x >= 1);
            if (on_grid) nbr = (x - 1) * h + y;
            wall = nbr;
          end
          default: begin
            on_grid = (y >= 1);
            if (on_grid) nbr = home - 1;
            wall = nbr;
            is_right = 1'b0;
          end
        endcase
        if (req.action == ACT_QUERY) begin
          if (on_grid) res.open_way = is_right ? !wall_east[wall] : !wall_south[wall];
        end else if (!on_grid) begin
          res.status = ST_OFF_GRID;
        end else begin
          ra = root_of(home);
          rb = root_of(nbr);
          if (ra != rb) begin
            if (is_right) wall_east[wall] = 1'b0;
            else wall_south[wall] = 1'b0;
            set_link[rb] = CELL_W'(ra);
            res.status = ST_REMOVED;
          end else begin
            res.status = ST_CONNECTED;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 50) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // request driver
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_replies.insert(expected_replies.size(), carve_step(in_data));
      if (!(in_valid && in_stall)) begin
        if (gap_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          gap_left = $urandom_range(1, 11);
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_requests.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall, with one long hold-off to back the core up
  int unsigned stall_left = 0;
  int unsigned taken_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) taken_cnt++;
      if (!hold_done && taken_cnt == 500) begin
        hold_done = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ufmc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: status %0d open %0d",
                                  out_data.status, out_data.open_way));
      end else begin
        want = expected_replies.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
        if (out_data.open_way !== want.open_way)
          report_mismatch($sformatf("open_way got %0d want %0d",
                                    out_data.open_way, want.open_way));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add(logic [1:0] act, int unsigned x, int unsigned y, dir_t dir);
    ufmc_in_t r;
    r.action = act;
    r.cell_x = COORD_W'(x);
    r.cell_y = COORD_W'(y);
    r.direction = dir;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_WIDTH) size_cols = val;
    else size_rows = val;
  endtask

  function automatic ufmc_in_t random_request();
    ufmc_in_t r;
    int unsigned w, h, pick;
    w = usable(size_cols, MAX_WIDTH);
    h = usable(size_rows, MAX_HEIGHT);
    pick = $urandom_range(0, 99);
    r.direction = 2'($urandom_range(0, 3));
    r.cell_x = COORD_W'($urandom_range(0, w - 1));
    r.cell_y = COORD_W'($urandom_range(0, h - 1));
    if (pick < 62) begin
      r.action = ACT_CARVE;
    end else if (pick < 84) begin
      r.action = ACT_QUERY;
    end else if (pick < 97) begin
      // anywhere in the coordinate range, mostly off the grid
      r.action = pick[0] ? ACT_CARVE : ACT_QUERY;
      r.cell_x = COORD_W'($urandom);
      r.cell_y = COORD_W'($urandom);
    end else if (pick < 99) begin
      r.action = ACT_IGNORED;
    end else begin
      r.action = ACT_CLEAR;
    end
    return r;
  endfunction

  task automatic run_phase(logic [SIZE_W-1:0] cols, logic [SIZE_W-1:0] rows, int unsigned count,
                           int unsigned pct, bit start_clean);
    ufmc_in_t r;
    int unsigned made;
    write_reg(CFG_GRID_WIDTH, cols);
    write_reg(CFG_GRID_HEIGHT, rows);
    @(negedge clk);
    idle_pct = pct;
    if (start_clean) add(ACT_CLEAR, 0, 0, DIR_RIGHT);
    made = 0;
    while (made < count) begin
      r = random_request();
      pending_requests.insert(pending_requests.size(), r);
      if (r.action != ACT_IGNORED) made++;
    end
    drain();
  endtask

  initial begin
    wipe_maze();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the reset grid of 32 x 32
    add(ACT_QUERY, 0, 0, DIR_RIGHT);
    add(ACT_CARVE, 0, 0, DIR_RIGHT);
    add(ACT_QUERY, 0, 0, DIR_RIGHT);
    add(ACT_QUERY, 1, 0, DIR_LEFT);
    add(ACT_CARVE, 1, 0, DIR_LEFT);
    add(ACT_CARVE, 0, 0, DIR_DOWN);
    add(ACT_CARVE, 0, 1, DIR_RIGHT);
    // closing a loop finds both cells in one set
    add(ACT_CARVE, 1, 1, DIR_UP);
    add(ACT_CARVE, 0, 0, DIR_LEFT);
    add(ACT_CARVE, 0, 0, DIR_UP);
    add(ACT_QUERY, 0, 0, DIR_UP);
    add(ACT_CARVE, 31, 31, DIR_RIGHT);
    add(ACT_QUERY, 31, 31, DIR_DOWN);
    add(ACT_CARVE, 31, 31, DIR_UP);
    add(ACT_QUERY, 31, 30, DIR_DOWN);
    add(ACT_CARVE, 31, 31, DIR_LEFT);
    add(ACT_IGNORED, 31, 31, DIR_UP);
    add(ACT_CLEAR, 0, 0, DIR_RIGHT);
    add(ACT_QUERY, 0, 0, DIR_RIGHT);
    drain();

    // addressed cell beyond the grid; no clear, so old walls are reindexed
    write_reg(CFG_GRID_WIDTH, 6'd5);
    write_reg(CFG_GRID_HEIGHT, 6'd3);
    add(ACT_CARVE, 5, 0, DIR_RIGHT);
    add(ACT_QUERY, 0, 3, DIR_DOWN);
    add(ACT_CARVE, 4, 2, DIR_RIGHT);
    add(ACT_CARVE, 4, 2, DIR_LEFT);
    drain();

    // zero size counts as one
    write_reg(CFG_GRID_WIDTH, 6'd0);
    write_reg(CFG_GRID_HEIGHT, 6'd0);
    add(ACT_CARVE, 0, 0, DIR_RIGHT);
    add(ACT_QUERY, 0, 0, DIR_LEFT);
    add(ACT_CARVE, 1, 0, DIR_DOWN);
    drain();

    run_phase(6'd8, 6'd8, 250, 10, 1'b1);
    run_phase(6'd1, 6'd32, 150, 25, 1'b1);
    run_phase(6'd32, 6'd1, 150, 0, 1'b1);
    run_phase(6'd5, 6'd7, 250, 30, 1'b0);
    run_phase(6'd3, 6'd0, 150, 10, 1'b1);
    run_phase(6'd16, 6'd16, 300, 10, 1'b1);
    run_phase(6'd33, 6'd2, 150, 15, 1'b1);
    run_phase(6'd63, 6'd63, 200, 10, 1'b1);
    // closing stretch runs without idling
    run_phase(6'd6, 6'd6, 200, 0, 1'b1);

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
